// ===== rtl/lpfc_pkg.sv =====
// Package for the LRU page fault counter: shared constants, item codes
// and the controller state type. No dependencies.
`default_nettype none
package lpfc_pkg;

    // Built store depth and configuration reset value
    localparam int LPFC_MAX_FRAMES  = 128;
    localparam int LPFC_CAP_WIDTH   = 8;
    localparam int LPFC_CAP_RESET   = 4;
    localparam int LPFC_PAGE_WIDTH  = 32;
    localparam int LPFC_COUNT_WIDTH = 32;

    // Item kind carried on the input tuser bit
    localparam logic LPFC_KIND_ACCESS = 1'b0;
    localparam logic LPFC_KIND_CLEAR  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/lpfc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none
module lpfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lru_page_fault_counter.sv =====
// Top level of the LRU page fault counter: controller, ring addressing and
// output register around one frame RAM. Depends on lpfc_pkg and lpfc_ram.
//
// Channel  Dir  Handshake                      Payload (low bit first)
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready tdata = page, tuser = kind
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready tdata = fault_count, tuser = hit
// cfg      in   i_cfg_valid/o_cfg_ready        i_cfg_data = capacity
//
// An access item runs through S_SCAN (one RAM read per resident frame, then
// the read data of the last one), S_FIN (scan end and write-back) and S_OUT,
// which loads the output register once that register is free. A clear item
// goes straight from S_IDLE to S_OUT; ready returns after each load.
// Reset is synchronous, active low; it empties the store and zeroes the count.
// A stalled output holds its item; the next input item is taken meanwhile.
`default_nettype none
module lru_page_fault_counter
    import lpfc_pkg::*;
#(
    parameter int MAX_FRAMES = LPFC_MAX_FRAMES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input items
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [LPFC_PAGE_WIDTH-1:0]  i_s_axis_tdata,   // [31:0] page
    input  wire logic                        i_s_axis_tuser,   // [0] kind
    // result items
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [LPFC_COUNT_WIDTH-1:0]      o_m_axis_tdata,   // [31:0] fault_count
    output logic                             o_m_axis_tuser,   // [0] hit
    // capacity register write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [LPFC_CAP_WIDTH-1:0]   i_cfg_data
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int UW = (CW > LPFC_CAP_WIDTH) ? CW : LPFC_CAP_WIDTH;
    localparam int SW = CW + 1;

    t_state r_state, n_state;

    logic [LPFC_CAP_WIDTH-1:0]   r_capacity;
    logic [CW-1:0]               r_count;
    logic [LPFC_COUNT_WIDTH-1:0] r_fault;
    logic [AW-1:0]               r_head;
    logic [LPFC_PAGE_WIDTH-1:0]  r_page;
    logic                        r_found;
    logic                        r_pend;
    logic [CW-1:0]               r_issue;
    logic [AW-1:0]               r_rd_addr;
    logic [AW-1:0]               r_data_addr;
    logic [AW-1:0]               r_prev_addr;
    logic                        r_res_hit;
    logic                        r_m_valid;
    logic                        r_m_hit;
    logic [LPFC_COUNT_WIDTH-1:0] r_m_fault;

    logic                        in_acc;
    logic                        scan_done;
    logic                        out_load;
    logic                        full;
    logic [UW-1:0]               cap_ext;
    logic [UW-1:0]               usable;
    logic [SW-1:0]               app_sum;
    logic [AW-1:0]               app_addr;
    logic [AW-1:0]               rd_addr_inc;
    logic [AW-1:0]               head_inc;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [LPFC_PAGE_WIDTH-1:0]  ram_wdata;
    logic                        ram_re;
    logic [LPFC_PAGE_WIDTH-1:0]  ram_rdata;

    // Frame store
    lpfc_ram #(
        .WIDTH (LPFC_PAGE_WIDTH),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // Handshake terms
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign scan_done = (r_issue == r_count) && !r_pend;
    assign out_load  = (r_state == S_OUT) && (!r_m_valid || i_m_axis_tready);
    assign o_cfg_ready = 1'b1;

    // Frames in use: zero acts as one, clipped to the built depth
    always_comb begin
        cap_ext = UW'(r_capacity);
        if (cap_ext == '0) begin
            usable = UW'(1);
        end else if (cap_ext > UW'(MAX_FRAMES)) begin
            usable = UW'(MAX_FRAMES);
        end else begin
            usable = cap_ext;
        end
    end
    assign full = !(UW'(r_count) < usable);

    // Ring address arithmetic
    assign rd_addr_inc = (r_rd_addr == AW'(MAX_FRAMES - 1)) ? '0 : r_rd_addr + AW'(1);
    assign head_inc    = (r_head == AW'(MAX_FRAMES - 1)) ? '0 : r_head + AW'(1);
    always_comb begin
        app_sum = SW'(r_head) + SW'(r_count);
        if (app_sum >= SW'(MAX_FRAMES)) begin
            app_sum = app_sum - SW'(MAX_FRAMES);
        end
        app_addr = app_sum[AW-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_axis_tuser == LPFC_KIND_CLEAR) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: input ready and RAM port control
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_prev_addr;
        ram_wdata       = ram_rdata;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_SCAN: begin
                ram_re = (r_issue != r_count);
                // after the hit, each later frame moves down one place
                ram_we = r_pend && r_found;
            end
            S_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_found ? r_prev_addr : app_addr;
                ram_wdata = r_page;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LPFC_CAP_WIDTH'(LPFC_CAP_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Store occupancy, ring head and fault total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fault <= '0;
            r_head  <= '0;
        end else if (r_state == S_IDLE && in_acc && i_s_axis_tuser == LPFC_KIND_CLEAR) begin
            r_count <= '0;
            r_fault <= '0;
        end else if (r_state == S_FIN && !r_found) begin
            if (r_fault != '1) begin
                r_fault <= r_fault + LPFC_COUNT_WIDTH'(1);
            end
            if (!full) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_head <= head_inc;
            end
        end
    end

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_issue <= '0;
        end else if (r_state == S_IDLE) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_issue <= '0;
        end else if (r_state == S_SCAN) begin
            r_pend <= ram_re;
            if (ram_re) begin
                r_issue <= r_issue + CW'(1);
            end
            if (r_pend && !r_found && ram_rdata == r_page) begin
                r_found <= 1'b1;
            end
        end
    end

    // Scan addresses and item payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rd_addr <= r_head;
            if (in_acc) begin
                r_page <= i_s_axis_tdata;
            end
        end else if (r_state == S_SCAN) begin
            if (ram_re) begin
                r_rd_addr   <= rd_addr_inc;
                r_data_addr <= r_rd_addr;
            end
            if (r_pend) begin
                r_prev_addr <= r_data_addr;
            end
        end
        if (r_state == S_IDLE) begin
            r_res_hit <= 1'b0;
        end else if (r_state == S_FIN) begin
            r_res_hit <= r_found;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_hit   <= r_res_hit;
            r_m_fault <= r_fault;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_fault;
    assign o_m_axis_tuser  = r_m_hit;

endmodule
`default_nettype wire

// ===== rtl/lpfc_checker.sv =====
// Port-level checker for the LRU page fault counter, bound to the top level.
// Depends on lpfc_pkg.
`default_nettype none
module lpfc_checker
    import lpfc_pkg::*;
(
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_axis_tvalid,
    input wire logic                        o_s_axis_tready,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [LPFC_COUNT_WIDTH-1:0] o_m_axis_tdata,
    input wire logic                        o_m_axis_tuser
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_outstanding;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Items taken but whose result is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 2'(in_acc) - 2'(out_acc);
        end
    end

    // One item in work at a time: ready drops right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    // No result without an item behind it
    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_outstanding != 2'd0)
        else $error("result delivered with no item outstanding");

    // At most one item in work plus one waiting in the output register
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding != 2'd3)
        else $error("more than two items outstanding");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lru_page_fault_counter lpfc_checker u_lpfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

// ===== dv/lru_page_fault_counter_tb.sv =====
// Testbench for the LRU page fault counter: drives page and clear items, predicts
// hit flag and fault count with its own LRU store, and checks every result item.
// Depends on lpfc_pkg and lru_page_fault_counter.
`timescale 1ns / 1ps

// Expected result of one item
typedef struct {
    bit        hit;
    bit [31:0] count;
} t_fault_result;

// LRU store predictor and result checker
class lru_scoreboard;
    bit [31:0]     frames [lpfc_pkg::LPFC_MAX_FRAMES];
    int unsigned   resident;
    bit [31:0]     faults;
    bit [7:0]      capacity;
    t_fault_result expected_q [$];
    int unsigned   mismatches;

    function new();
        resident   = 0;
        faults     = 0;
        capacity   = lpfc_pkg::LPFC_CAP_RESET;
        mismatches = 0;
    endfunction

    function void set_capacity(bit [7:0] value);
        capacity = value;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // drop the frame at pos, close the gap, put page in the most recent slot
    function void move_to_recent(int unsigned pos, bit [31:0] page);
        int unsigned k;
        for (k = pos; k + 1 < resident; k++)
            frames[k] = frames[k + 1];
        frames[resident - 1] = page;
    endfunction

    // predict the result of an accepted input item
    function void note_item(bit kind, bit [31:0] page);
        t_fault_result r;
        int            pos;
        int unsigned   frames_usable;
        int unsigned   k;
        if (kind == lpfc_pkg::LPFC_KIND_CLEAR) begin
            resident = 0;
            faults   = 0;
            r.hit    = 1'b0;
            r.count  = '0;
        end else begin
            pos = -1;
            for (k = 0; k < resident; k++) begin
                if (frames[k] == page) begin
                    pos = k;
                    break;
                end
            end
            // zero capacity acts as one, large values clip to the store depth
            frames_usable = (capacity == 0) ? 1 : capacity;
            if (frames_usable > lpfc_pkg::LPFC_MAX_FRAMES)
                frames_usable = lpfc_pkg::LPFC_MAX_FRAMES;
            if (pos >= 0) begin
                move_to_recent(pos, page);
            end else begin
                // over-full store after a capacity drop only evicts, never grows
                if (resident < frames_usable) begin
                    frames[resident] = page;
                    resident++;
                end else begin
                    move_to_recent(0, page);
                end
                if (faults != 32'hFFFF_FFFF)
                    faults++;
            end
            r.hit   = (pos >= 0);
            r.count = faults;
        end
        expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // compare an accepted result item with the oldest prediction
    task check_result(bit hit, bit [31:0] count);
        t_fault_result r;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result hit=%0b count=%0d", hit, count));
        end else begin
            r = expected_q.pop_front();
            if (hit != r.hit)
                report($sformatf("hit %0b, expected %0b", hit, r.hit));
            if (count != r.count)
                report($sformatf("fault_count %0d, expected %0d", count, r.count));
        end
    endtask
endclass

module lru_page_fault_counter_tb;
    import lpfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          POOL_SIZE   = 160;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = LPFC_KIND_ACCESS;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data      = '0;

    lru_scoreboard sb = new();
    bit            idle_on = 1'b1;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left = 0;
    bit [31:0]     page_pool [POOL_SIZE];

    lru_page_fault_counter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_m_axis_tready = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left      = $urandom_range(0, 6);
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
    end

    // send one item, with an occasional idle burst ahead of it
    task send_item(bit kind, bit [31:0] page);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = page;
        i_s_axis_tuser  = kind;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sb.note_item(kind, page);
    endtask

    task stop_sending();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // capacity write once every prediction has been matched
    task write_capacity(bit [7:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        sb.set_capacity(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly reused pages from a pool sized around the capacity, some fresh
    // pages and a few clears; optional drain halfway through
    task run_random(int n, int frames_usable, bit drain_mid);
        int pool_n;
        int i;
        int pick;
        pool_n = frames_usable + frames_usable / 2 + 2;
        if (pool_n > POOL_SIZE)
            pool_n = POOL_SIZE;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_item(LPFC_KIND_CLEAR, $urandom);
            else if (pick < 84)
                send_item(LPFC_KIND_ACCESS, page_pool[$urandom_range(0, pool_n - 1)]);
            else
                send_item(LPFC_KIND_ACCESS, $urandom);
            if (drain_mid && i == n / 2) begin
                stop_sending();
                wait_drained();
            end
        end
        stop_sending();
    endtask

    initial begin
        foreach (page_pool[k])
            page_pool[k] = $urandom;
        page_pool[0] = '0;
        page_pool[1] = '1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset capacity of four, fill, hits at both ends,
        // eviction, clears with nonzero page fields, extreme page numbers
        send_item(LPFC_KIND_ACCESS, 32'h0000_0010);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0020);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0030);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0040);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0040);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0010);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0050);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0020);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0040);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0010);
        send_item(LPFC_KIND_CLEAR,  32'hFFFF_FFFF);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0000);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0000);
        send_item(LPFC_KIND_ACCESS, 32'hFFFF_FFFF);
        send_item(LPFC_KIND_ACCESS, 32'hFFFF_FFFF);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0000);
        send_item(LPFC_KIND_CLEAR,  32'h0000_0000);
        send_item(LPFC_KIND_CLEAR,  32'hA5A5_5A5A);
        send_item(LPFC_KIND_ACCESS, 32'hFFFF_FFFF);
        stop_sending();

        // zero capacity behaves as one frame
        write_capacity(8'd0);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0001);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0001);
        send_item(LPFC_KIND_ACCESS, 32'h0000_0002);
        run_random(100, 1, 1'b0);

        write_capacity(8'd1);
        run_random(100, 1, 1'b0);

        write_capacity(8'd7);
        run_random(300, 7, 1'b1);

        // full depth, then shrink to three frames
        write_capacity(8'd128);
        run_random(200, 128, 1'b0);
        write_capacity(8'd3);
        run_random(100, 3, 1'b0);

        // above the store depth clips to it
        write_capacity(8'd255);
        send_item(LPFC_KIND_CLEAR, 32'h0);
        run_random(150, 128, 1'b0);

        // last stretch without idling on either side
        write_capacity(8'd16);
        idle_on = 1'b0;
        run_random(500, 16, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpfc_pkg.sv
rtl/lpfc_ram.sv
rtl/lru_page_fault_counter.sv
rtl/lpfc_checker.sv
dv/lru_page_fault_counter_tb.sv
